### rtl/fla_pkg.sv
package fla_pkg;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   typedef enum logic [1:0] {
      ST_OK           = 2'd0,
      ST_EMPTY        = 2'd1,
      ST_ALREADY_FREE = 2'd2
   } status_type;

   typedef enum logic {
      BK_IDLE = 1'b0,
      BK_EXEC = 1'b1
   } back_state_type;

   // classified command handed from front to back
   typedef struct packed {
      logic is_alloc;
      logic in_range;
   } cmd_type;

endpackage

### rtl/fla_front.sv
module fla_front #(
   parameter int POOL_ENTRIES = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic                              req_opcode,
   input  logic [9:0]                        req_entry_index,
   output logic                              q_valid,
   output fla_pkg::cmd_type                  q_cmd,
   output logic [$clog2(POOL_ENTRIES)-1:0]   q_idx,
   input  logic                              q_pop
);

   localparam int IDX_W = $clog2(POOL_ENTRIES);
   localparam int XW    = (IDX_W > 10) ? IDX_W : 10;

   fla_pkg::cmd_type       cmd_q_ff [2];
   logic [IDX_W-1:0]       idx_q_ff [2];
   logic                   wr_ptr_ff, wr_ptr_in;
   logic                   rd_ptr_ff, rd_ptr_in;
   logic [1:0]             count_ff, count_in;
   logic                   push;
   fla_pkg::cmd_type       cmd_new;
   logic [XW-1:0]          idx_wide;

   assign busy     = (count_ff == 2'd2);
   assign push     = start && !busy;
   assign idx_wide = XW'(req_entry_index);

   always_comb begin
      cmd_new.is_alloc = (req_opcode == fla_pkg::OP_ALLOC);
      cmd_new.in_range = (32'(req_entry_index) < 32'(POOL_ENTRIES));
   end

   always_comb begin
      wr_ptr_in = push  ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         cmd_q_ff[wr_ptr_ff] <= cmd_new;
         idx_q_ff[wr_ptr_ff] <= idx_wide[IDX_W-1:0];
      end
   end

   assign q_valid = (count_ff != 2'd0);
   assign q_cmd   = cmd_q_ff[rd_ptr_ff];
   assign q_idx   = idx_q_ff[rd_ptr_ff];

endmodule

### rtl/fla_back.sv
module fla_back #(
   parameter int POOL_ENTRIES = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              q_valid,
   input  fla_pkg::cmd_type                  q_cmd,
   input  logic [$clog2(POOL_ENTRIES)-1:0]   q_idx,
   output logic                              q_pop,
   output logic                              rsp_valid,
   output logic [9:0]                        rsp_granted_index,
   output logic [1:0]                        rsp_status,
   output logic [10:0]                       rsp_free_count
);

   localparam int IDX_W = $clog2(POOL_ENTRIES);
   localparam int LNK_W = $clog2(POOL_ENTRIES + 1);
   localparam int GW    = (IDX_W > 10) ? IDX_W : 10;
   localparam int CW    = (LNK_W > 11) ? LNK_W : 11;
   localparam logic [LNK_W-1:0] LINK_NULL = LNK_W'(POOL_ENTRIES);

   // entries at or above fresh_ff were never touched: link i+1, not in use
   logic [LNK_W-1:0]            link_mem [POOL_ENTRIES];
   logic                        mark_mem [POOL_ENTRIES];

   fla_pkg::back_state_type     state_ff, state_in;
   logic [LNK_W-1:0]            head_ff, head_in;
   logic [LNK_W-1:0]            total_ff, total_in;
   logic [LNK_W-1:0]            fresh_ff, fresh_in;
   fla_pkg::cmd_type            cmd_ff;
   logic [IDX_W-1:0]            idx_ff;
   logic [LNK_W-1:0]            link_rd_ff;
   logic                        mark_rd_ff;

   logic                        link_we;
   logic [IDX_W-1:0]            link_wa;
   logic [LNK_W-1:0]            link_wd;
   logic                        mark_we;
   logic [IDX_W-1:0]            mark_wa;
   logic                        mark_wd;
   logic                        head_touched;
   logic                        idx_touched;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]            granted_in;
   fla_pkg::status_type         status_in;
   logic [9:0]                  rsp_granted_ff;
   logic [1:0]                  rsp_status_ff;
   logic [10:0]                 rsp_count_ff;
   logic [GW-1:0]               granted_ext;
   logic [CW-1:0]               count_ext;

   assign head_touched = (head_ff < fresh_ff);
   assign idx_touched  = (LNK_W'(idx_ff) < fresh_ff);

   always_comb begin
      state_in     = state_ff;
      q_pop        = 1'b0;
      head_in      = head_ff;
      total_in     = total_ff;
      fresh_in     = fresh_ff;
      link_we      = 1'b0;
      link_wa      = head_ff[IDX_W-1:0];
      link_wd      = LINK_NULL;
      mark_we      = 1'b0;
      mark_wa      = head_ff[IDX_W-1:0];
      mark_wd      = 1'b1;
      rsp_valid_in = 1'b0;
      granted_in   = '0;
      status_in    = fla_pkg::ST_OK;
      unique case (state_ff)
         fla_pkg::BK_IDLE: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               state_in = fla_pkg::BK_EXEC;
            end
         end
         fla_pkg::BK_EXEC: begin
            state_in     = fla_pkg::BK_IDLE;
            rsp_valid_in = 1'b1;
            if (cmd_ff.is_alloc) begin
               if (head_ff == LINK_NULL) begin
                  status_in = fla_pkg::ST_EMPTY;
               end else begin
                  granted_in = head_ff[IDX_W-1:0];
                  head_in    = head_touched ? link_rd_ff : head_ff + LNK_W'(1);
                  link_we    = 1'b1;
                  mark_we    = 1'b1;
                  total_in   = total_ff - LNK_W'(1);
                  if (!head_touched) begin
                     fresh_in = head_ff + LNK_W'(1);
                  end
               end
            end else if (cmd_ff.in_range && idx_touched && mark_rd_ff) begin
               link_we  = 1'b1;
               link_wa  = idx_ff;
               link_wd  = head_ff;
               mark_we  = 1'b1;
               mark_wa  = idx_ff;
               mark_wd  = 1'b0;
               head_in  = LNK_W'(idx_ff);
               total_in = total_ff + LNK_W'(1);
            end else begin
               status_in = fla_pkg::ST_ALREADY_FREE;
            end
         end
         default: state_in = fla_pkg::BK_IDLE;
      endcase
   end

   assign granted_ext = GW'(granted_in);
   assign count_ext   = CW'(total_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fla_pkg::BK_IDLE;
         head_ff      <= '0;
         total_ff     <= LNK_W'(POOL_ENTRIES);
         fresh_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         total_ff     <= total_in;
         fresh_ff     <= fresh_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         cmd_ff     <= q_cmd;
         idx_ff     <= q_idx;
         link_rd_ff <= link_mem[head_ff[IDX_W-1:0]];
         mark_rd_ff <= mark_mem[q_idx];
      end
      if (link_we) begin
         link_mem[link_wa] <= link_wd;
      end
      if (mark_we) begin
         mark_mem[mark_wa] <= mark_wd;
      end
      if (rsp_valid_in) begin
         rsp_granted_ff <= granted_ext[9:0];
         rsp_status_ff  <= status_in;
         rsp_count_ff   <= count_ext[10:0];
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_granted_index = rsp_granted_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_free_count    = rsp_count_ff;

endmodule

### rtl/free_list_entry_allocator.sv
// Free-list entry allocator: hands out and takes back entry indexes of a
// fixed pool, managed as a LIFO free list held in a link memory.
// Request channel: a word (req_opcode, req_entry_index) is taken at a clock
// edge where start is high and busy is low. Opcode allocate pops the head, or
// reports empty; opcode free pushes an in-use, in-range index onto the head.
// Response channel: one word per request, on rsp_* for exactly one cycle
// while rsp_valid is high; the receiver cannot stall it, so it must take it.
// Path: the accepted word is written into the queue, then popped into the
// execute stage with the memory reads, and its response is registered.
// The back end takes no new word until it has finished the last: the link and
// in-use memories are read synchronously before the head and marks update.
// A two-word queue sits between request decode and execution; busy is high
// while that queue is full.
// Reset: synchronous; afterwards all POOL_ENTRIES entries are free in order
// 0, 1, 2, ... with no clearing pass: a fill pointer marks entries never
// touched, which read as linked to the next index and not in use.
module free_list_entry_allocator #(
   parameter int POOL_ENTRIES = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_opcode,
   input  logic [9:0]  req_entry_index,
   output logic        rsp_valid,
   output logic [9:0]  rsp_granted_index,
   output logic [1:0]  rsp_status,
   output logic [10:0] rsp_free_count
);

   localparam int IDX_W = $clog2(POOL_ENTRIES);

   logic              q_valid;
   logic              q_pop;
   fla_pkg::cmd_type  q_cmd;
   logic [IDX_W-1:0]  q_idx;

   fla_front #(.POOL_ENTRIES(POOL_ENTRIES)) u_front (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_opcode      (req_opcode),
      .req_entry_index (req_entry_index),
      .q_valid         (q_valid),
      .q_cmd           (q_cmd),
      .q_idx           (q_idx),
      .q_pop           (q_pop)
   );

   fla_back #(.POOL_ENTRIES(POOL_ENTRIES)) u_back (
      .clock             (clock),
      .reset             (reset),
      .q_valid           (q_valid),
      .q_cmd             (q_cmd),
      .q_idx             (q_idx),
      .q_pop             (q_pop),
      .rsp_valid         (rsp_valid),
      .rsp_granted_index (rsp_granted_index),
      .rsp_status        (rsp_status),
      .rsp_free_count    (rsp_free_count)
   );

endmodule

### rtl/fla_checker.sv
module fla_checker (
   input logic        clock,
   input logic        reset,
   input logic        busy,
   input logic        rsp_valid,
   input logic [9:0]  rsp_granted_index,
   input logic [1:0]  rsp_status,
   input logic [10:0] rsp_free_count
);

   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid && !busy)
      else $error("response or busy right after reset");

   a_spacing: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("responses closer than two cycles");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == fla_pkg::ST_OK || rsp_status == fla_pkg::ST_EMPTY ||
                     rsp_status == fla_pkg::ST_ALREADY_FREE))
      else $error("undefined status code");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != fla_pkg::ST_OK |-> rsp_granted_index == 10'd0)
      else $error("nonzero index on failed request");

   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == fla_pkg::ST_EMPTY |-> rsp_free_count == 11'd0)
      else $error("pool empty reported with free entries left");

endmodule

bind free_list_entry_allocator fla_checker u_fla_checker (.*);
